// ===== hdl/fhts_pkg.sv =====
`default_nettype none

package fhts_pkg;

	localparam int TARGET_SLOTS = 64;
	localparam int SLOT_AW = (TARGET_SLOTS > 1) ? $clog2(TARGET_SLOTS) : 1;
	localparam int CNT_W = $clog2(TARGET_SLOTS + 1);

	localparam int ADDR_W = 32;
	localparam int PORT_W = 16;
	localparam int IDX_W = 6;
	localparam int HASH_W = 32;
	localparam int KEY_W = 128;
	localparam int FLOW_W = 2 * ADDR_W + 2 * PORT_W;
	localparam int GROUPS = FLOW_W / HASH_W;

	localparam int CFG_AW = 2;
	localparam int CFG_DW = 64;
	localparam int ACT_W = 7;
	localparam logic [CFG_AW-1:0] CFG_KEY_UPPER = 2'd0;
	localparam logic [CFG_AW-1:0] CFG_KEY_LOWER = 2'd1;
	localparam logic [CFG_AW-1:0] CFG_ACTIVE = 2'd2;
	localparam logic [CFG_DW-1:0] KEY_UPPER_RST = 64'hDE00_0000_0000_0000;
	localparam logic [CFG_DW-1:0] KEY_LOWER_RST = 64'h0;
	localparam logic [ACT_W-1:0] ACTIVE_RST = 7'd1;

	localparam int IN_SIP_LSB = 0;
	localparam int IN_DIP_LSB = IN_SIP_LSB + ADDR_W;
	localparam int IN_SPORT_LSB = IN_DIP_LSB + ADDR_W;
	localparam int IN_DPORT_LSB = IN_SPORT_LSB + PORT_W;
	localparam int IN_ENTRY_IDX_LSB = IN_DPORT_LSB + PORT_W;
	localparam int IN_ENTRY_ADDR_LSB = IN_ENTRY_IDX_LSB + IDX_W;
	localparam int IN_USED_W = IN_ENTRY_ADDR_LSB + ADDR_W;
	localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

	localparam int OUT_ADDR_LSB = 0;
	localparam int OUT_TIDX_LSB = OUT_ADDR_LSB + ADDR_W;
	localparam int OUT_HASH_LSB = OUT_TIDX_LSB + IDX_W;
	localparam int OUT_USED_W = OUT_HASH_LSB + HASH_W;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

	localparam int DIV_STEP = 4;
	localparam int DIV_STAGES = HASH_W / DIV_STEP;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW = $clog2(Q_DEPTH);

	typedef struct packed {
		logic              cls;
		logic [HASH_W-1:0] word;
		logic [IDX_W-1:0]  slot;
	} fhts_job_t;

endpackage

`default_nettype wire

// ===== hdl/fhts_ram.sv =====
`default_nettype none

module fhts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fhts_front.sv =====
`default_nettype none

module fhts_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               in_op,
	input  logic [fhts_pkg::IN_DATA_W-1:0]     in_data,
	input  logic [fhts_pkg::KEY_W-1:0]         key,
	input  logic [fhts_pkg::CNT_W-1:0]         count,
	output logic                               job_valid,
	input  logic                               job_ready,
	output fhts_pkg::fhts_job_t                job
);
	import fhts_pkg::*;

	logic                  adv;
	logic [FLOW_W-1:0]     flow;
	logic [HASH_W-1:0]     part [GROUPS];

	logic                  v_s1;
	logic                  cls_s1;
	logic [HASH_W-1:0]     part_s1 [GROUPS];
	logic [ADDR_W-1:0]     addr_s1;
	logic [IDX_W-1:0]      idx_s1;

	logic                  v_s2;
	logic                  cls_s2;
	logic [HASH_W-1:0]     word_s2;
	logic [IDX_W-1:0]      idx_s2;
	logic [HASH_W-1:0]     hash_s1;

	logic                  div_v_s    [DIV_STAGES];
	logic                  div_cls_s  [DIV_STAGES];
	logic [HASH_W-1:0]     div_word_s [DIV_STAGES];
	logic [IDX_W-1:0]      div_idx_s  [DIV_STAGES];
	logic [CNT_W-1:0]      div_rem_s  [DIV_STAGES];

	assign flow = {in_data[IN_DIP_LSB +: ADDR_W], in_data[IN_SIP_LSB +: ADDR_W],
		in_data[IN_DPORT_LSB +: PORT_W], in_data[IN_SPORT_LSB +: PORT_W]};

	assign adv = !div_v_s[DIV_STAGES-1] || job_ready;
	assign in_ready = adv;

	// bit j of the hash takes key bit i+31-j for every set flow bit i (msb-first numbering)
	always_comb begin
		logic [HASH_W-1:0] terms;
		terms = '0;
		for (int g = 0; g < GROUPS; g++) begin
			for (int j = 0; j < HASH_W; j++) begin
				for (int ii = 0; ii < HASH_W; ii++) begin
					terms[ii] = flow[FLOW_W-1-(g*HASH_W+ii)]
						& key[KEY_W-HASH_W-(g*HASH_W+ii)+j];
				end
				part[g][j] = ^terms;
			end
		end
	end

	always_comb begin
		hash_s1 = '0;
		for (int g = 0; g < GROUPS; g++) begin
			hash_s1 = hash_s1 ^ part_s1[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cls_s1 <= in_op;
			part_s1 <= part;
			addr_s1 <= in_data[IN_ENTRY_ADDR_LSB +: ADDR_W];
			idx_s1 <= in_data[IN_ENTRY_IDX_LSB +: IDX_W];
			cls_s2 <= cls_s1;
			word_s2 <= cls_s1 ? hash_s1 : addr_s1;
			idx_s2 <= idx_s1;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		logic              v_in;
		logic              cls_in;
		logic [HASH_W-1:0] word_in;
		logic [IDX_W-1:0]  idx_in;
		logic [CNT_W-1:0]  rem_in;
		logic [CNT_W-1:0]  rem_nxt;

		if (k == 0) begin : g_first
			assign v_in = v_s2;
			assign cls_in = cls_s2;
			assign word_in = word_s2;
			assign idx_in = idx_s2;
			assign rem_in = '0;
		end else begin : g_next
			assign v_in = div_v_s[k-1];
			assign cls_in = div_cls_s[k-1];
			assign word_in = div_word_s[k-1];
			assign idx_in = div_idx_s[k-1];
			assign rem_in = div_rem_s[k-1];
		end

		always_comb begin
			logic [CNT_W:0]   t;
			logic [CNT_W-1:0] r;
			r = rem_in;
			t = '0;
			for (int b = 0; b < DIV_STEP; b++) begin
				t = {r, word_in[HASH_W-1-DIV_STEP*k-b]};
				if (t >= {1'b0, count}) begin
					t = t - {1'b0, count};
				end
				r = t[CNT_W-1:0];
			end
			rem_nxt = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k] <= 1'b0;
			end else if (adv) begin
				div_v_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_cls_s[k] <= cls_in;
				div_word_s[k] <= word_in;
				div_idx_s[k] <= idx_in;
				div_rem_s[k] <= rem_nxt;
			end
		end
	end

	assign job_valid = div_v_s[DIV_STAGES-1];
	assign job.cls = div_cls_s[DIV_STAGES-1];
	assign job.word = div_word_s[DIV_STAGES-1];
	assign job.slot = div_cls_s[DIV_STAGES-1] ? IDX_W'(div_rem_s[DIV_STAGES-1])
		: div_idx_s[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== hdl/fhts_fifo.sv =====
`default_nettype none

module fhts_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  fhts_pkg::fhts_job_t in_job,
	output logic                out_valid,
	input  logic                out_ready,
	output fhts_pkg::fhts_job_t out_job
);
	import fhts_pkg::*;

	fhts_job_t       mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   cnt_q;
	logic            push;
	logic            pop;

	assign in_ready = cnt_q != (Q_AW+1)'(Q_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_job = mem_q[rd_ptr_q];
	assign push = in_valid && in_ready;
	assign pop = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_AW'(Q_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_AW'(Q_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/fhts_back.sv =====
`default_nettype none

module fhts_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            job_valid,
	output logic                            job_ready,
	input  fhts_pkg::fhts_job_t             job,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fhts_pkg::OUT_DATA_W-1:0] out_data
);
	import fhts_pkg::*;

	logic              adv_s1;
	logic              load_s1;
	logic              pop;
	logic              rd_en;
	logic              wr_en;
	logic [ADDR_W-1:0] rd_data;

	logic              rd_v_s1;
	logic [IDX_W-1:0]  rd_idx_s1;
	logic [HASH_W-1:0] rd_hash_s1;

	logic              out_v_q;
	logic [ADDR_W-1:0] out_addr_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [HASH_W-1:0] out_hash_q;

	assign adv_s1 = !out_v_q || out_ready;
	assign load_s1 = !rd_v_s1 || adv_s1;
	assign job_ready = !job.cls || load_s1;
	assign pop = job_valid && job_ready;
	assign rd_en = pop && job.cls;
	assign wr_en = pop && !job.cls && (32'(job.slot) < 32'(TARGET_SLOTS));

	fhts_ram #(
		.WIDTH(ADDR_W),
		.DEPTH(TARGET_SLOTS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (SLOT_AW'(job.slot)),
		.wr_data (job.word[ADDR_W-1:0]),
		.rd_en   (rd_en),
		.rd_addr (SLOT_AW'(job.slot)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (load_s1) begin
				rd_v_s1 <= rd_en;
			end
			if (adv_s1) begin
				out_v_q <= rd_v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1 <= job.slot;
			rd_hash_s1 <= job.word;
		end
		if (adv_s1 && rd_v_s1) begin
			out_addr_q <= rd_data;
			out_idx_q <= rd_idx_s1;
			out_hash_q <= rd_hash_s1;
		end
	end

	assign out_valid = out_v_q;
	assign out_data = {(OUT_DATA_W-OUT_USED_W)'(0), out_hash_q, out_idx_q, out_addr_q};

endmodule

`default_nettype wire

// ===== hdl/flow_hash_target_select_top.sv =====
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid / s_axis_tready  tdata: flow and table entry, tuser: op
// m_axis    out        m_axis_tvalid / m_axis_tready  tdata: target address, index, hash
// cfg       in         cfg_we                         cfg_addr, cfg_wdata
//
// One item per cycle in steady state while m_axis_tready is held high.
// A classify passes the hash stage, the combine stage and eight 4-bit remainder stages,
// then the queue and the table read port with its output register.
// Reset clears the key to its default, the active count to one, and empties every stage.
// The table holds no reset value; a slot reads back only what was written to it.
// A stalled output fills the output register, the table read stage and the queue,
// then holds the front pipeline and drops s_axis_tready.
`default_nettype none

module flow_hash_target_select_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// source address, destination address, source port, destination port,
	// entry_index, entry_address, zero fill
	input  logic [fhts_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// op
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// target_addr, target_index, flow_hash, zero fill
	output logic [fhts_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	input  logic                             cfg_we,
	input  logic [fhts_pkg::CFG_AW-1:0]      cfg_addr,
	input  logic [fhts_pkg::CFG_DW-1:0]      cfg_wdata
);
	import fhts_pkg::*;

	logic [CFG_DW-1:0] key_upper_q;
	logic [CFG_DW-1:0] key_lower_q;
	logic [ACT_W-1:0]  active_q;
	logic [CNT_W-1:0]  eff_cnt;

	logic              fe_valid;
	logic              fe_ready;
	fhts_job_t         fe_job;
	logic              be_valid;
	logic              be_ready;
	fhts_job_t         be_job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= KEY_UPPER_RST;
			key_lower_q <= KEY_LOWER_RST;
			active_q <= ACTIVE_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_KEY_UPPER: begin
					key_upper_q <= cfg_wdata;
				end
				CFG_KEY_LOWER: begin
					key_lower_q <= cfg_wdata;
				end
				CFG_ACTIVE: begin
					active_q <= cfg_wdata[ACT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		if (active_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (32'(active_q) > 32'(TARGET_SLOTS)) begin
			eff_cnt = CNT_W'(TARGET_SLOTS);
		end else begin
			eff_cnt = CNT_W'(active_q);
		end
	end

	fhts_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.key       ({key_upper_q, key_lower_q}),
		.count     (eff_cnt),
		.job_valid (fe_valid),
		.job_ready (fe_ready),
		.job       (fe_job)
	);

	fhts_fifo u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fe_valid),
		.in_ready  (fe_ready),
		.in_job    (fe_job),
		.out_valid (be_valid),
		.out_ready (be_ready),
		.out_job   (be_job)
	);

	fhts_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (be_valid),
		.job_ready (be_ready),
		.job       (be_job),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (32'(m_axis_tdata[OUT_TIDX_LSB +: IDX_W]) < 32'(eff_cnt)))
		else $error("target index not below active count");

	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fe_valid && !fe_ready |=> fe_valid && $stable(fe_job))
		else $error("front dropped or changed a transaction while queue was full");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> fe_valid && !fe_ready)
		else $error("input stalled without a full queue");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fhts_pkg::*;

	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	localparam int RESET_CYCLES    = 12;
	localparam int SETTLE_CYCLES   = 20;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int RANDOM_ITEMS    = 540;
	localparam int PRINT_CAP       = 100;

	typedef struct {
		logic [ADDR_W-1:0] addr;
		logic [IDX_W-1:0]  idx;
		logic [HASH_W-1:0] hash;
	} route_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic                  s_axis_tuser = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_AW-1:0]     cfg_addr = '0;
	logic [CFG_DW-1:0]     cfg_wdata = '0;

	logic [CFG_DW-1:0] key_hi = KEY_UPPER_RST;
	logic [CFG_DW-1:0] key_lo = KEY_LOWER_RST;
	logic [ACT_W-1:0]  active_cfg = ACTIVE_RST;
	logic [ADDR_W-1:0] backend_table [TARGET_SLOTS];
	bit                slot_written [TARGET_SLOTS];
	route_t            route_q [$];

	bit tx_idle_en = 1'b1;
	bit rx_idle_en = 1'b1;
	int hold_off_asked = 0;
	int mismatches = 0;
	int items_sent = 0;
	int entry_writes = 0;
	int flows_sent = 0;
	int results_checked = 0;
	int cfg_writes = 0;
	int idle_cycles = 0;

	flow_hash_target_select_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [HASH_W-1:0] toeplitz_hash(input logic [ADDR_W-1:0] src,
			input logic [ADDR_W-1:0] dst, input logic [PORT_W-1:0] sp,
			input logic [PORT_W-1:0] dp);
		logic [KEY_W-1:0]  key;
		logic [FLOW_W-1:0] flow;
		logic [HASH_W-1:0] h;
		key = {key_hi, key_lo};
		flow = {dst, src, dp, sp};
		h = '0;
		for (int i = 0; i < FLOW_W; i++) begin
			if (flow[FLOW_W-1-i])
				h ^= key[KEY_W-1-i -: HASH_W];
		end
		return h;
	endfunction

	function automatic logic [31:0] active_count();
		if (active_cfg == 0)
			return 32'd1;
		if (active_cfg > TARGET_SLOTS)
			return 32'(TARGET_SLOTS);
		return 32'(active_cfg);
	endfunction

	function automatic route_t predict_route(input logic [ADDR_W-1:0] src,
			input logic [ADDR_W-1:0] dst, input logic [PORT_W-1:0] sp,
			input logic [PORT_W-1:0] dp);
		route_t r;
		r.hash = toeplitz_hash(src, dst, sp, dp);
		r.idx = IDX_W'(r.hash % active_count());
		r.addr = backend_table[r.idx];
		return r;
	endfunction

	function automatic logic [31:0] pick_word();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return $urandom();
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic push_item(input logic op, input logic [ADDR_W-1:0] src,
			input logic [ADDR_W-1:0] dst, input logic [PORT_W-1:0] sp,
			input logic [PORT_W-1:0] dp, input logic [IDX_W-1:0] eidx,
			input logic [ADDR_W-1:0] eaddr);
		logic [IN_DATA_W-1:0] d;
		int gap;
		d = '0;
		d[IN_SIP_LSB +: ADDR_W] = src;
		d[IN_DIP_LSB +: ADDR_W] = dst;
		d[IN_SPORT_LSB +: PORT_W] = sp;
		d[IN_DPORT_LSB +: PORT_W] = dp;
		d[IN_ENTRY_IDX_LSB +: IDX_W] = eidx;
		d[IN_ENTRY_ADDR_LSB +: ADDR_W] = eaddr;
		gap = tx_idle_en ? idle_len() : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		if (op == OP_WRITE) begin
			backend_table[eidx] = eaddr;
			slot_written[eidx] = 1'b1;
			entry_writes++;
		end else begin
			route_q.push_back(predict_route(src, dst, sp, dp));
			flows_sent++;
		end
	endtask

	task automatic push_entry(input logic [IDX_W-1:0] eidx, input logic [ADDR_W-1:0] eaddr);
		push_item(OP_WRITE, $urandom(), $urandom(), PORT_W'($urandom()), PORT_W'($urandom()),
			eidx, eaddr);
	endtask

	// fill the selected slot first so that no classify reads an unwritten entry
	task automatic push_flow(input logic [ADDR_W-1:0] src, input logic [ADDR_W-1:0] dst,
			input logic [PORT_W-1:0] sp, input logic [PORT_W-1:0] dp);
		route_t r;
		r = predict_route(src, dst, sp, dp);
		if (!slot_written[r.idx])
			push_entry(r.idx, pick_word());
		push_item(OP_CLASSIFY, src, dst, sp, dp, IDX_W'($urandom()), $urandom());
	endtask

	task automatic push_random_flow();
		push_flow(pick_word(), pick_word(), PORT_W'(pick_word()), PORT_W'(pick_word()));
	endtask

	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (route_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [CFG_DW-1:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
			CFG_KEY_UPPER: key_hi = value;
			CFG_KEY_LOWER: key_lo = value;
			CFG_ACTIVE: active_cfg = value[ACT_W-1:0];
			default: ;
		endcase
		cfg_writes++;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_active(input int count);
		write_reg(CFG_ACTIVE, CFG_DW'(ACT_W'(count)));
	endtask

	task automatic test_reset_defaults();
		push_entry('0, 32'h0A00_0001);
		push_flow('0, '0, '0, '0);
		push_flow('1, '1, '1, '1);
		push_flow('0, 32'h8000_0000, '0, '0);
	endtask

	task automatic test_field_extremes();
		quiesce();
		write_reg(CFG_KEY_UPPER, '1);
		write_reg(CFG_KEY_LOWER, '1);
		set_active(TARGET_SLOTS);
		push_entry(IDX_W'(TARGET_SLOTS - 1), '1);
		push_entry('0, '0);
		push_flow('1, '1, '1, '1);
		push_flow('1, '0, '0, '0);
		push_flow('0, '1, '0, '0);
		push_flow('0, '0, '1, '1);
		push_flow('0, '0, 16'h0001, '0);
		quiesce();
		write_reg(CFG_KEY_UPPER, '0);
		write_reg(CFG_KEY_LOWER, {$urandom(), $urandom()});
		push_random_flow();
	endtask

	task automatic test_zero_active();
		quiesce();
		write_reg(CFG_KEY_UPPER, {$urandom(), $urandom()});
		set_active(0);
		push_random_flow();
		push_random_flow();
	endtask

	task automatic test_active_saturation();
		quiesce();
		set_active(127);
		push_random_flow();
		push_random_flow();
		quiesce();
		set_active(TARGET_SLOTS + 1);
		push_random_flow();
	endtask

	// back-to-back rewrites of the one slot in use, each followed by a flow, then a write to an unused slot
	task automatic test_table_overwrite();
		logic [ADDR_W-1:0] src;
		src = $urandom();
		quiesce();
		set_active(1);
		tx_idle_en = 1'b0;
		push_entry('0, $urandom());
		push_flow(src, '1, '0, '1);
		push_entry('0, $urandom());
		push_flow(src, '1, '0, '1);
		push_entry(IDX_W'($urandom_range(1, TARGET_SLOTS - 1)), $urandom());
		push_flow(src, '1, '0, '1);
		tx_idle_en = 1'b1;
	endtask

	task automatic test_backpressure();
		quiesce();
		set_active(TARGET_SLOTS);
		tx_idle_en = 1'b0;
		hold_off_asked++;
		repeat (48) push_random_flow();
		quiesce();
		tx_idle_en = 1'b1;
	endtask

	task automatic test_random_phases();
		int left;
		int len;
		int r;
		logic [CFG_DW-1:0] ku;
		logic [CFG_DW-1:0] kl;
		logic [ADDR_W-1:0] l_src;
		logic [ADDR_W-1:0] l_dst;
		logic [PORT_W-1:0] l_sp;
		logic [PORT_W-1:0] l_dp;
		left = RANDOM_ITEMS;
		l_src = $urandom();
		l_dst = $urandom();
		l_sp = PORT_W'($urandom());
		l_dp = PORT_W'($urandom());
		while (left > 0) begin
			quiesce();
			case ($urandom_range(0, 7))
				0: begin ku = '0; kl = '0; end
				1: begin ku = '1; kl = '1; end
				2: begin ku = KEY_UPPER_RST; kl = KEY_LOWER_RST; end
				default: begin ku = {$urandom(), $urandom()}; kl = {$urandom(), $urandom()}; end
			endcase
			write_reg(CFG_KEY_UPPER, ku);
			write_reg(CFG_KEY_LOWER, kl);
			case ($urandom_range(0, 9))
				0: set_active(1);
				1: set_active(TARGET_SLOTS);
				2: set_active(0);
				3: set_active($urandom_range(TARGET_SLOTS + 1, 127));
				default: set_active($urandom_range(2, TARGET_SLOTS - 1));
			endcase
			tx_idle_en = ($urandom_range(0, 3) != 0);
			rx_idle_en = ($urandom_range(0, 3) != 0);
			len = $urandom_range(30, 90);
			if (len > left)
				len = left;
			left -= len;
			repeat (len) begin
				r = $urandom_range(0, 99);
				if (r < 20) begin
					push_entry(IDX_W'($urandom()), pick_word());
				end else if (r < 28) begin
					push_flow(l_src, l_dst, l_sp, l_dp);
				end else begin
					l_src = pick_word();
					l_dst = pick_word();
					l_sp = PORT_W'(pick_word());
					l_dp = PORT_W'(pick_word());
					push_flow(l_src, l_dst, l_sp, l_dp);
				end
				if ($urandom_range(0, 99) < 2) begin
					s_axis_tvalid <= 1'b0;
					do @(posedge clk); while (route_q.size() != 0);
				end
			end
		end
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;
	endtask

	initial begin
		for (int i = 0; i < TARGET_SLOTS; i++) begin
			backend_table[i] = '0;
			slot_written[i] = 1'b0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_zero_active();
		test_active_saturation();
		test_table_overwrite();
		test_backpressure();
		test_random_phases();
		quiesce();
		$display("Sent %0d items: %0d table writes and %0d flows, across %0d register writes",
			items_sent, entry_writes, flows_sent, cfg_writes);
		$display("Checked %0d results, incl. zero and saturated active counts and output hold-off",
			results_checked);
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		int n;
		int taken;
		taken = 0;
		forever begin
			@(posedge clk);
			if (taken != hold_off_asked) begin
				taken = hold_off_asked;
				n = HOLD_OFF_CYCLES;
			end else if (rx_idle_en) begin
				n = idle_len();
			end else begin
				n = 0;
			end
			if (n > 0) begin
				m_axis_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		route_t want;
		logic [ADDR_W-1:0] got_addr;
		logic [IDX_W-1:0]  got_idx;
		logic [HASH_W-1:0] got_hash;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				got_addr = m_axis_tdata[OUT_ADDR_LSB +: ADDR_W];
				got_idx = m_axis_tdata[OUT_TIDX_LSB +: IDX_W];
				got_hash = m_axis_tdata[OUT_HASH_LSB +: HASH_W];
				if (route_q.size() == 0) begin
					report_mismatch("result with nothing pending", 64'(got_hash), '0);
				end else begin
					want = route_q.pop_front();
					results_checked++;
					if (got_addr !== want.addr)
						report_mismatch("target_addr", 64'(got_addr), 64'(want.addr));
					if (got_idx !== want.idx)
						report_mismatch("target_index", 64'(got_idx), 64'(want.idx));
					if (got_hash !== want.hash)
						report_mismatch("flow_hash", 64'(got_hash), 64'(want.hash));
				end
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog: no transaction for %0d cycles, %0d results pending",
					idle_cycles, route_q.size());
				$display("Test completed with failures");
				$finish;
			end
		end
	end

endmodule
